[src/clsr_pkg.sv]
`timescale 1ns / 1ps
// Package for the combined LCG / shuffle-table random generator.
// Generator constants, state encoding and the modular reduce and slot helpers.
// No dependencies.
package clsr_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned WARMUP_STEPS  = 8;
  localparam int unsigned SEED_STEPS    = TABLE_ENTRIES + WARMUP_STEPS;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(SEED_STEPS + 1);

  localparam int unsigned VAL_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = MUL_W + VAL_W;

  localparam logic [MUL_W-1:0] A1  = 16'd40014;
  localparam logic [VAL_W-1:0] M1  = 31'd2147483563;
  localparam logic [MUL_W-1:0] A2  = 16'd40692;
  localparam logic [VAL_W-1:0] M2  = 31'd2147483399;
  localparam logic [VAL_W-1:0] MM1 = 31'd2147483562;
  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

  // slot divisor: 1 + MM1 / TABLE_ENTRIES
  localparam logic [VAL_W-1:0] JDIV = 31'(1 + (2147483562 / TABLE_ENTRIES));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SWAIT,
    ST_DSTEP,
    ST_DRAW
  } clsr_state_e;

  // (a * x) mod m for m = 2^31 - c, c < 256: fold the high part back once,
  // then one conditional subtract.
  function automatic logic [VAL_W-1:0] mod_reduce(input logic [PROD_W-1:0] p,
                                                  input logic [VAL_W-1:0]  m);
    logic [31:0] c;
    logic [23:0] hc;
    logic [31:0] t;
    c  = 32'h8000_0000 - {1'b0, m};
    hc = 24'(p[PROD_W-1:VAL_W]) * 24'(c[7:0]);
    t  = {1'b0, p[VAL_W-1:0]} + {8'h00, hc};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[VAL_W-1:0];
  endfunction

  // table slot = v / JDIV, clamped to the last slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [VAL_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int t = 1; t < int'(TABLE_ENTRIES); t++) begin
      if ({1'b0, v} >= 32'(t) * 32'(JDIV)) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage

[src/clsr_req_if.sv]
`timescale 1ns / 1ps
// Request channel: opcode and seed value with valid/ready.
// Uses clsr_pkg for the value width.
interface clsr_req_if;
  import clsr_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [VAL_W-1:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

[src/clsr_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: one random value per request, valid/ready.
// Uses clsr_pkg for the value width.
interface clsr_rsp_if;
  import clsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

[src/combined_lcg_shuffle_rng_top.sv]
`timescale 1ns / 1ps
// Top level of the combined LCG random generator with shuffle table.
// Depends on clsr_pkg, clsr_req_if, clsr_rsp_if and clsr_ram.

// Every request returns one 31-bit value in 1..2147483562. A plain draw
// (opcode 0) reads the shuffle-table slot picked by the previous output,
// then forms the result and writes the slot back. A reseed (opcode 1), and
// the first draw after reset, which seeds from default_seed, first runs the
// first generator through 40 multiply/reduce steps to warm it up and fill
// the 32-entry table, then steps both generators and draws as above. Each
// step goes through the registered 16x31 multiplier feeding the modular
// reduce. A new request is taken whenever the block is idle; the result
// sits in its own register, so an unread result does not hold off the next
// request, but that request holds in its final cycle until the previous
// result has been taken. default_seed should be written only while the
// block is idle.
module combined_lcg_shuffle_rng_top
  import clsr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             default_seed_we_i,
  input  logic [VAL_W-1:0] default_seed_i,
  clsr_req_if.sink         req_i,
  clsr_rsp_if.source       rsp_o
);

  clsr_state_e state_q, state_d;

  logic [VAL_W-1:0]  default_seed_q;
  logic [VAL_W-1:0]  first_q, first_d;     // first generator, also seeding iterate
  logic [VAL_W-1:0]  second_q, second_d;   // second generator
  logic [VAL_W-1:0]  last_q, last_d;       // previous output, picks the next slot
  logic [VAL_W-1:0]  result_q, result_d;   // drives the result port
  logic [CNT_W-1:0]  cnt_q, cnt_d;         // seeding steps left after the current one
  logic              phase_q, phase_d;     // seeding: 0 multiply, 1 reduce
  logic [IDX_W-1:0]  j_q, j_d;             // slot being drawn
  logic              seeded_q, seeded_d;
  logic              out_valid_q, out_valid_d;

  // Products are refreshed every cycle from the generator registers, so
  // each reflects the generator values of the cycle before.
  logic [PROD_W-1:0] prod1_q, prod2_q;
  logic [VAL_W-1:0]  red1, red2;

  logic [IDX_W-1:0]  slot_now;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  logic              req_fire;
  logic [VAL_W-1:0]  seed_src, seed_val;
  logic [31:0]       diff;
  logic [VAL_W-1:0]  y;

  assign red1     = mod_reduce(prod1_q, M1);
  assign red2     = mod_reduce(prod2_q, M2);
  assign slot_now = slot_of(last_q);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // zero seed behaves as one
  assign seed_src = req_i.opcode ? req_i.seed_value : default_seed_q;
  assign seed_val = (seed_src == '0) ? VAL_W'(1) : seed_src;

  // y = slot - second, wrapped into 1..MM1
  assign diff = {1'b0, ram_rdata} - {1'b0, second_q};
  assign y    = (diff[31] || diff == '0) ? VAL_W'(diff + {1'b0, MM1}) : diff[VAL_W-1:0];

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.random_value = result_q;

  clsr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_now),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    second_d    = second_q;
    last_d      = last_q;
    result_d    = result_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    j_d         = j_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = j_q;
    ram_wdata   = first_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.opcode || !seeded_q) begin
            first_d  = seed_val;
            second_d = seed_val;
            cnt_d    = CNT_W'(SEED_STEPS - 1);
            phase_d  = 1'b0;
            state_d  = ST_SEED;
          end else begin
            // step both generators; table read of slot_now is in flight
            first_d  = red1;
            second_d = red2;
            j_d      = slot_now;
            state_d  = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        phase_d = !phase_q;
        if (phase_q) begin
          first_d = red1;
          if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_q[IDX_W-1:0];
            ram_wdata = red1;
          end
          if (cnt_q == '0) begin
            last_d   = red1;
            seeded_d = 1'b1;
            state_d  = ST_SWAIT;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_SWAIT: begin
        // let the product catch up with the final seeding value
        state_d = ST_DSTEP;
      end
      ST_DSTEP: begin
        first_d  = red1;
        second_d = red2;
        j_d      = slot_now;
        state_d  = ST_DRAW;
      end
      ST_DRAW: begin
        // hold while the previous result is still unread; the slot read
        // repeats at the same address, so its data stays put
        if (!out_valid_q || rsp_o.ready) begin
          ram_we      = 1'b1;
          ram_waddr   = j_q;
          ram_wdata   = first_q;
          last_d      = y;
          result_d    = y;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      default_seed_q <= VAL_W'(1);
      first_q        <= '0;
      second_q       <= SECOND_RESET;
      last_q         <= '0;
      result_q       <= '0;
      cnt_q          <= '0;
      phase_q        <= 1'b0;
      seeded_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      last_q      <= last_d;
      result_q    <= result_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      if (default_seed_we_i) begin
        default_seed_q <= default_seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    prod1_q <= PROD_W'(A1) * PROD_W'(first_q);
    prod2_q <= PROD_W'(A2) * PROD_W'(second_q);
  end

endmodule

[src/clsr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
